/* hdl/rgre_pkg.sv */
// Shared types, constants and the luma function of the RGB565 gray
// run-length encoder. No dependencies.
`timescale 1ns / 1ps

package rgre_pkg;

  localparam int PIXEL_W = 16;
  localparam int GRAY_W  = 8;
  localparam int RUN_W   = 8;

  localparam logic [RUN_W-1:0] MAX_RUN = 8'd255;

  localparam logic [7:0] COEF_R = 8'd77;
  localparam logic [7:0] COEF_G = 8'd150;
  localparam logic [7:0] COEF_B = 8'd29;

  typedef logic [PIXEL_W-1:0] pixel_t;
  typedef logic [GRAY_W-1:0]  gray_t;
  typedef logic [RUN_W-1:0]   run_t;

  typedef struct packed {
    run_t  run_length;
    gray_t gray_value;
    logic  last_pair;
  } pair_t;

  // BT.601 luma, channels widened by zero fill; the sum stays below 2^16
  function automatic gray_t luma(input pixel_t px);
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [15:0] sum;
    r = {px[15:11], 3'b000};
    g = {px[10:5], 2'b00};
    b = {px[4:0], 3'b000};
    sum = 16'(r) * 16'(COEF_R) + 16'(g) * 16'(COEF_G) + 16'(b) * 16'(COEF_B);
    return sum[15:8];
  endfunction

endpackage

/* hdl/rgre_pix_if.sv */
// Pixel channel: valid/ready handshake with an RGB565 pixel and end-of-frame flag.
// Depends on rgre_pkg.
`timescale 1ns / 1ps

interface rgre_pix_if;
  import rgre_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t pixel;
  logic   last_pixel;

  modport source (output valid, output pixel, output last_pixel, input ready);
  modport sink   (input valid, input pixel, input last_pixel, output ready);
endinterface

/* hdl/rgre_pair_if.sv */
// Pair channel: valid/ready handshake with one run-length pair.
// Depends on rgre_pkg.
`timescale 1ns / 1ps

interface rgre_pair_if;
  import rgre_pkg::*;

  logic  valid;
  logic  ready;
  run_t  run_length;
  gray_t gray_value;
  logic  last_pair;

  modport source (output valid, output run_length, output gray_value, output last_pair,
                  input ready);
  modport sink   (input valid, input run_length, input gray_value, input last_pair,
                  output ready);
endinterface

/* hdl/rgre_luma.sv */
// Two-stage pipeline: input pixel register, then registered luma byte.
// Depends on rgre_pkg and rgre_pix_if.
`timescale 1ns / 1ps

module rgre_luma (
  input  logic          clk,
  input  logic          rst,
  rgre_pix_if.sink      pixels,
  output logic          y_valid,
  input  logic          y_ready,
  output rgre_pkg::gray_t y,
  output logic          y_last
);
  import rgre_pkg::*;

  logic   px_valid;
  pixel_t px;
  logic   px_last;
  logic   px_ready;
  logic   out_ready;

  assign out_ready    = !y_valid || y_ready;
  assign px_ready     = !px_valid || out_ready;
  assign pixels.ready = px_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      px_valid <= 1'b0;
      y_valid  <= 1'b0;
    end else begin
      if (px_ready) begin
        px_valid <= pixels.valid;
      end
      if (out_ready) begin
        y_valid <= px_valid;
      end
    end
    if (px_ready && pixels.valid) begin
      px      <= pixels.pixel;
      px_last <= pixels.last_pixel;
    end
    if (out_ready && px_valid) begin
      y      <= luma(px);
      y_last <= px_last;
    end
  end

endmodule

/* hdl/rgre_rle.sv */
// Run tracker and two-entry pair buffer; one luma item may close a run and
// flush the final one in the same cycle. Depends on rgre_pkg, rgre_pair_if.
`timescale 1ns / 1ps

module rgre_rle (
  input  logic            clk,
  input  logic            rst,
  input  logic            y_valid,
  output logic            y_ready,
  input  rgre_pkg::gray_t y,
  input  logic            y_last,
  rgre_pair_if.source     pairs
);
  import rgre_pkg::*;

  gray_t open_value;
  run_t  open_count;
  pair_t q0;
  pair_t q1;
  logic [1:0] count;

  gray_t      open_value_next;
  run_t       open_count_next;
  pair_t      q0_next;
  pair_t      q1_next;
  logic [1:0] count_next;

  logic       close_run;
  logic       start_run;
  run_t       run_cnt;
  gray_t      run_val;
  pair_t      push_a;
  pair_t      push_b;
  logic [1:0] need;
  logic [1:0] free;
  logic       pop;
  logic       take;
  logic [1:0] kept;
  logic [1:0] n_push;
  pair_t      head;

  assign pop = pairs.valid && pairs.ready;

  always_comb begin
    close_run = (open_count != '0) && ((y != open_value) || (open_count >= MAX_RUN));
    start_run = close_run || (open_count == '0);
    run_cnt   = start_run ? run_t'(1) : run_t'(open_count + 1'b1);
    run_val   = start_run ? y : open_value;
    need      = {1'b0, close_run} + {1'b0, y_last};
    free      = 2'd2 - count + {1'b0, pop};
    y_ready   = need <= free;
    take      = y_valid && y_ready;

    if (close_run) begin
      push_a = '{run_length: open_count, gray_value: open_value, last_pair: 1'b0};
      push_b = '{run_length: run_cnt, gray_value: run_val, last_pair: 1'b1};
    end else begin
      push_a = '{run_length: run_cnt, gray_value: run_val, last_pair: 1'b1};
      push_b = push_a;
    end

    open_value_next = open_value;
    open_count_next = open_count;
    n_push          = '0;
    if (take) begin
      n_push = need;
      if (y_last) begin
        open_value_next = '0;
        open_count_next = '0;
      end else begin
        open_value_next = run_val;
        open_count_next = run_cnt;
      end
    end

    kept = count - {1'b0, pop};
    head = pop ? q1 : q0;
    q0_next = head;
    q1_next = q1;
    case (kept)
      2'd0: begin
        q0_next = push_a;
        q1_next = push_b;
      end
      2'd1: begin
        q0_next = head;
        q1_next = push_a;
      end
      default: begin
        q0_next = q0;
        q1_next = q1;
      end
    endcase
    count_next = kept + n_push;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_value <= '0;
      open_count <= '0;
      count      <= '0;
    end else begin
      open_value <= open_value_next;
      open_count <= open_count_next;
      count      <= count_next;
    end
    q0 <= q0_next;
    q1 <= q1_next;
  end

  assign pairs.valid      = count != '0;
  assign pairs.run_length = q0.run_length;
  assign pairs.gray_value = q0.gray_value;
  assign pairs.last_pair  = q0.last_pair;

endmodule

/* hdl/rgb565_gray_rle_encoder.sv */
// Top level of the RGB565 gray run-length encoder.
// Depends on rgre_pkg, rgre_pix_if, rgre_pair_if, rgre_luma, rgre_rle.
//
// Usage:
//   pixels: one RGB565 pixel per item with last_pixel marking the frame end.
//   pairs:  (run_length, gray_value, last_pair) items; last_pair marks the
//           final pair of a frame, after which no run is open.
// Path: pixel register, luma register, then the pair buffer that feeds pairs.
// Throughput: one pixel per cycle while the receiver keeps up. A pixel that
// both closes a run and ends the frame makes two pairs; the second one waits
// behind the first in the two-entry pair buffer. Another two-pair pixel waits
// until the buffer can take both, since pairs leave at most one per cycle.
// Reset (rst, synchronous): pipeline and pair buffer empty, no run open.
// Receiver stall: the pair buffer fills, then the luma stages fill and
// pixels.ready drops; nothing is lost. A pixel that fits the open run
// makes no pair and can still be taken while a pair waits.
`timescale 1ns / 1ps

module rgb565_gray_rle_encoder (
  input  logic        clk,
  input  logic        rst,
  rgre_pix_if.sink    pixels,
  rgre_pair_if.source pairs
);
  import rgre_pkg::*;

  logic  y_valid;
  logic  y_ready;
  gray_t y;
  logic  y_last;

  rgre_luma u_luma (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pixels),
    .y_valid (y_valid),
    .y_ready (y_ready),
    .y       (y),
    .y_last  (y_last)
  );

  rgre_rle u_rle (
    .clk     (clk),
    .rst     (rst),
    .y_valid (y_valid),
    .y_ready (y_ready),
    .y       (y),
    .y_last  (y_last),
    .pairs   (pairs)
  );

endmodule

/* hdl/rgre_checker.sv */
// Port-level checks for the RGB565 gray run-length encoder, bound to the top.
// Depends on rgre_pkg.
`timescale 1ns / 1ps

module rgre_checker (
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_ready,
  input rgre_pkg::run_t  run_length,
  input rgre_pkg::gray_t gray_value,
  input logic            last_pair
);
  import rgre_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(run_length) &&
      $stable(gray_value) && $stable(last_pair))
    else $error("pair changed while stalled");

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> run_length != '0)
    else $error("pair with zero run length");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("pair shown right after reset");

  a_short_run_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_pair && run_length != MAX_RUN ##1
      out_valid && !last_pair |-> gray_value != $past(gray_value))
    else $error("non-final short run followed by same value");

endmodule

bind rgb565_gray_rle_encoder rgre_checker u_rgre_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (pairs.valid),
  .out_ready  (pairs.ready),
  .run_length (pairs.run_length),
  .gray_value (pairs.gray_value),
  .last_pair  (pairs.last_pair)
);

/* bench/rgb565_gray_rle_encoder_tb.sv */
// Testbench for rgb565_gray_rle_encoder: drives pixel frames, predicts the gray run pairs
// and checks every pair with random idling on both channels.
// Depends on rgre_pkg, rgre_pix_if, rgre_pair_if and the encoder RTL.
`timescale 1ns / 1ps

module rgb565_gray_rle_encoder_tb;
  import rgre_pkg::*;

  localparam int RUN_LIMIT      = 255;
  localparam int RANDOM_ITEMS   = 520;
  localparam int MAX_PRINTS     = 200;
  localparam int DRAIN_CYCLES   = 8;
  localparam int IDLE_PCT       = 24;

  logic clk;
  logic rst;

  rgre_pix_if  pix_bus();
  rgre_pair_if pair_bus();

  rgb565_gray_rle_encoder dut (
    .clk    (clk),
    .rst    (rst),
    .pixels (pix_bus),
    .pairs  (pair_bus)
  );

  int    error_count;
  int    src_idle_pct;
  int    sink_stall_pct;
  pair_t expected_pairs[$];
  gray_t run_value;
  int    run_count;

  always #5 clk = ~clk;

  task automatic report_error(input string msg);
    if (error_count < MAX_PRINTS) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
    error_count++;
  endtask

  function automatic gray_t gray_of(input pixel_t px);
    int unsigned red8;
    int unsigned grn8;
    int unsigned blu8;
    int unsigned weighted;
    red8 = {px[15:11], 3'b000};
    grn8 = {px[10:5], 2'b00};
    blu8 = {px[4:0], 3'b000};
    weighted = red8 * 77 + grn8 * 150 + blu8 * 29;
    return gray_t'(weighted >> 8);
  endfunction

  task automatic push_pair(input int count, input gray_t value, input logic fin);
    pair_t p;
    p.run_length = run_t'(count);
    p.gray_value = value;
    p.last_pair  = fin;
    expected_pairs.push_back(p);
  endtask

  task automatic predict_pairs(input pixel_t px, input logic last);
    gray_t y;
    y = gray_of(px);
    if (run_count != 0 && (y != run_value || run_count >= RUN_LIMIT)) begin
      push_pair(run_count, run_value, 1'b0);
      run_count = 0;
    end
    if (run_count == 0) begin
      run_value = y;
      run_count = 1;
    end else begin
      run_count++;
    end
    if (last) begin
      push_pair(run_count, run_value, 1'b1);
      run_count = 0;
      run_value = '0;
    end
  endtask

  // starts and ends on a rising edge; valid stays high only until the next task lowers it
  task automatic send_pixel(input pixel_t px, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_bus.valid <= 1'b0;
      @(negedge clk);
    end
    pix_bus.valid      <= 1'b1;
    pix_bus.pixel      <= px;
    pix_bus.last_pixel <= last;
    @(posedge clk);
    while (!pix_bus.ready) @(posedge clk);
    predict_pairs(px, last);
  endtask

  task automatic wait_for_pairs();
    @(negedge clk);
    pix_bus.valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    pair_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    pair_t want;
    if (!rst && pair_bus.valid && pair_bus.ready) begin
      if (expected_pairs.size() == 0) begin
        report_error($sformatf("unexpected pair len=%0d gray=%0d last=%0b",
                               pair_bus.run_length, pair_bus.gray_value, pair_bus.last_pair));
      end else begin
        want = expected_pairs.pop_front();
        if (pair_bus.run_length !== want.run_length)
          report_error($sformatf("run_length got %0d want %0d",
                                 pair_bus.run_length, want.run_length));
        if (pair_bus.gray_value !== want.gray_value)
          report_error($sformatf("gray_value got %0d want %0d",
                                 pair_bus.gray_value, want.gray_value));
        if (pair_bus.last_pair !== want.last_pair)
          report_error($sformatf("last_pair got %0b want %0b",
                                 pair_bus.last_pair, want.last_pair));
      end
    end
  end

  task automatic test_directed();
    src_idle_pct   = IDLE_PCT;
    sink_stall_pct = IDLE_PCT;
    // one-pixel frames at the extremes
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'hFFFF, 1'b1);
    // pure channels; the last one closes a run and ends the frame
    send_pixel(16'hF800, 1'b0);
    send_pixel(16'h07E0, 1'b0);
    send_pixel(16'h001F, 1'b1);
    // different pixels with equal luma extend the run; the last one differs and closes it
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'h0001, 1'b0);
    send_pixel(16'h0002, 1'b1);
    repeat (3) send_pixel(16'h1234, 1'b0);
    send_pixel(16'h1234, 1'b1);
    send_pixel(16'hAAAA, 1'b0);
    send_pixel(16'h5555, 1'b0);
    send_pixel(16'h8410, 1'b0);
    send_pixel(16'h7BEF, 1'b1);
    // frame with no last pixel yet, flushed by a different final pixel
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0000, 1'b1);
    wait_for_pairs();
  endtask

  // full-rate stretch: runs that hit the length limit
  task automatic test_run_limit();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    repeat (RUN_LIMIT) send_pixel(16'hC618, 1'b0);
    send_pixel(16'hC618, 1'b1);
    repeat (299) send_pixel(16'h39E7, 1'b0);
    send_pixel(16'h39E7, 1'b1);
    wait_for_pairs();
  endtask

  task automatic test_random_frames();
    int     sent;
    int     frames;
    int     n_runs;
    int     run_len;
    pixel_t px;
    pixel_t cur;
    logic   fin;
    src_idle_pct   = IDLE_PCT;
    sink_stall_pct = IDLE_PCT;
    sent   = 0;
    frames = 0;
    while (sent < RANDOM_ITEMS) begin
      n_runs = $urandom_range(1, 12);
      for (int r = 0; r < n_runs && sent < RANDOM_ITEMS; r++) begin
        px = pixel_t'($urandom_range(0, 65535));
        if ($urandom_range(49) == 0)
          run_len = $urandom_range(200, 300);
        else
          run_len = $urandom_range(1, 6);
        for (int k = 0; k < run_len && sent < RANDOM_ITEMS; k++) begin
          cur = px;
          if ($urandom_range(6) == 0)
            cur = pixel_t'($urandom_range(0, 65535));
          else if ($urandom_range(3) == 0)
            cur[0] = ~cur[0];
          // the item budget also ends the frame
          fin = ((r == n_runs - 1) && (k == run_len - 1)) || (sent == RANDOM_ITEMS - 1);
          send_pixel(cur, fin);
          sent++;
        end
      end
      frames++;
      // hold the sender off until the pair channel has caught up
      if (frames % 8 == 0) wait_for_pairs();
    end
    wait_for_pairs();
  endtask

  initial begin
    clk                 = 1'b0;
    rst                 = 1'b1;
    error_count         = 0;
    src_idle_pct        = IDLE_PCT;
    sink_stall_pct      = IDLE_PCT;
    run_value           = '0;
    run_count           = 0;
    pix_bus.valid       = 1'b0;
    pix_bus.pixel       = '0;
    pix_bus.last_pixel  = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_run_limit();
    test_random_frames();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout, %0d pairs outstanding", expected_pairs.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
